// File: rtl/core/pida_pkg.sv
`timescale 1ns / 1ps
// Package for the positional insert/delete array.
// Holds field widths, operation and status codes and the result struct; no dependencies.
package pida_pkg;

  localparam int KIND_W       = 2;
  localparam int POS_W        = 5;
  localparam int WORD_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;
  localparam int CAPACITY_DEF = 16;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] data;
    logic [COUNT_W-1:0]       count;
  } result_t;

endpackage

// File: rtl/core/pida_mem.sv
`timescale 1ns / 1ps
// Entry store: one write port and one registered read port.
// Depends on pida_pkg for the word width.
module pida_mem
  import pida_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = $clog2(CAPACITY_DEF)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [WORD_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [WORD_W-1:0] rd_data
);

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/pida_out.sv
`timescale 1ns / 1ps
// Output register that holds one result beat until it is taken.
// Depends on pida_pkg for the result struct.
module pida_out
  import pida_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       res_valid,
  output logic                       res_ready,
  input  result_t                    res,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [WORD_W-1:0]   out_data,
  output logic [COUNT_W-1:0]         out_count
);

  result_t res_r;
  logic    out_valid_r;

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = res_r.status;
  assign out_data   = res_r.data;
  assign out_count  = res_r.count;

endmodule

// File: rtl/core/pida_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that checks each operation and moves entries through the store one per cycle.
// Depends on pida_pkg for codes, widths and the result struct.
module pida_ctrl
  import pida_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY_DEF),
  parameter int FW       = $clog2(CAPACITY_DEF + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     res_valid,
  input  logic                     res_ready,
  output result_t                  res,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic signed [WORD_W-1:0] wr_data,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  logic signed [WORD_W-1:0] rd_data
);

  localparam int CW = (FW > POS_W) ? FW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SHIFT = 3'b010,
    S_RESP  = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  logic [FW-1:0]            fill_r, fill_nxt;
  logic [KIND_W-1:0]        kind_r, kind_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic signed [WORD_W-1:0] val_r, val_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic signed [WORD_W-1:0] data_r, data_nxt;
  logic [AW-1:0]            cur_r, cur_nxt;
  logic [FW-1:0]            left_r, left_nxt;
  logic                     rv_r, rv_nxt;
  logic [AW-1:0]            ra_r, ra_nxt;

  logic [CW-1:0] pos_ext;
  logic [CW-1:0] fill_ext;
  logic [CW-1:0] diff;

  assign pos_ext  = CW'(in_position);
  assign fill_ext = CW'(fill_r);
  assign diff     = fill_ext - pos_ext;

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    kind_nxt   = kind_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    data_nxt   = data_r;
    cur_nxt    = cur_r;
    left_nxt   = left_r;
    rv_nxt     = rv_r;
    ra_nxt     = ra_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = pos_r;
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = cur_r;
    res.status = status_r;
    res.data   = data_r;
    res.count  = COUNT_W'(fill_r);
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt   = in_kind;
          pos_nxt    = AW'(in_position);
          val_nxt    = in_value;
          status_nxt = ST_DONE;
          data_nxt   = '0;
          rv_nxt     = 1'b0;
          cur_nxt    = AW'(in_position);
          left_nxt   = FW'(diff);
          state_nxt  = S_SHIFT;
          unique case (in_kind)
            KIND_INSERT: begin
              cur_nxt = AW'(fill_r - FW'(1));
              if (pos_ext > fill_ext) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_RESP;
              end else if (fill_ext >= CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end
            end
            KIND_DELETE: begin
              if (pos_ext >= fill_ext) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_RESP;
              end
            end
            KIND_READ: begin
              left_nxt = FW'(1);
              if (pos_ext >= fill_ext) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_RESP;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_SHIFT: begin
        rv_nxt = 1'b0;
        if (rv_r) begin
          unique case (kind_r)
            KIND_READ: begin
              data_nxt = rd_data;
            end
            KIND_DELETE: begin
              if (ra_r == pos_r) begin
                data_nxt = rd_data;
              end else begin
                wr_en   = 1'b1;
                wr_addr = ra_r - AW'(1);
              end
            end
            KIND_INSERT: begin
              wr_en   = 1'b1;
              wr_addr = ra_r + AW'(1);
            end
            default: begin
            end
          endcase
        end
        if (left_r != '0) begin
          rd_en    = 1'b1;
          rv_nxt   = 1'b1;
          ra_nxt   = cur_r;
          left_nxt = left_r - FW'(1);
          cur_nxt  = (kind_r == KIND_INSERT) ? cur_r - AW'(1) : cur_r + AW'(1);
        end else if (!rv_r) begin
          state_nxt = S_RESP;
          if (kind_r == KIND_INSERT) begin
            wr_en    = 1'b1;
            wr_addr  = pos_r;
            wr_data  = val_r;
            fill_nxt = fill_r + FW'(1);
          end else if (kind_r == KIND_DELETE) begin
            fill_nxt = fill_r - FW'(1);
          end
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      rv_r    <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    data_r   <= data_nxt;
    cur_r    <= cur_nxt;
    left_r   <= left_nxt;
    ra_r     <= ra_nxt;
  end

endmodule

// File: rtl/core/positional_insert_delete_array.sv
`timescale 1ns / 1ps
// Positional insert/delete array: an ordered list of signed words in a store with one read port
// and one write port.
// A rejected item or one of the unused kind goes straight to its result, a read fetches its one
// entry from the store, and an insert or delete moves the later entries by one place per cycle
// through the store's one read and one write port. The next beat is taken as soon as the
// previous result sits in the output register. Count reports the number of stored words
// modulo 32, and no clearing pass follows reset.
module positional_insert_delete_array
  import pida_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [WORD_W-1:0] out_data,
  output logic [COUNT_W-1:0]       out_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int FW = $clog2(CAPACITY + 1);

  logic                     res_valid;
  logic                     res_ready;
  result_t                  res;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [WORD_W-1:0] wr_data;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [WORD_W-1:0] rd_data;

  pida_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .FW       (FW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_position (in_position),
    .in_value    (in_value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  pida_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pida_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_data   (out_data),
    .out_count  (out_count)
  );

endmodule

// File: rtl/core/pida_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the positional insert/delete array, bound to the top level.
// Depends on pida_pkg for status codes and widths.
module pida_chk
  import pida_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STATUS_W-1:0]      out_status,
  input logic signed [WORD_W-1:0] out_data,
  input logic [COUNT_W-1:0]       out_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_data)
      && $stable(out_count))
    else $error("Result beat changed while stalled.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_BADPOS || out_status == ST_FULL))
    else $error("Result beat carries an undefined status.");

  a_err_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_data == '0)
    else $error("Rejected operation returned nonzero data.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_count == COUNT_W'(CAPACITY))
    else $error("Full status reported with a count below capacity.");

endmodule

bind positional_insert_delete_array pida_chk #(.CAPACITY(CAPACITY)) u_pida_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_status (out_status),
  .out_data   (out_data),
  .out_count  (out_count)
);

// File: bench/tb_positional_insert_delete_array.sv
`timescale 1ns / 1ps
// Self-checking testbench for positional_insert_delete_array: directed table, then random beats.
// Depends on pida_pkg and the RTL top; a local list model predicts each result beat the table does not give.
module tb_positional_insert_delete_array;
  import pida_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int IDLE_PCT     = 26;
  localparam int RANDOM_ITEMS = 1400;
  localparam int SETTLE       = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] val;
    bit                       typed;
    result_t                  want;
  } step_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [KIND_W-1:0]        in_kind = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [WORD_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic signed [WORD_W-1:0] out_data;
  logic [COUNT_W-1:0]       out_count;

  logic signed [WORD_W-1:0] slots [CAPACITY];
  int                       stored = 0;
  result_t                  pending_results [$];
  step_row_t                script [$];
  result_t                  oldest;
  bit                       calm = 1'b0;
  int                       failures = 0;
  int                       cycles = 0;

  positional_insert_delete_array u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_position (in_position),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_data    (out_data),
    .out_count   (out_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_t list_outcome(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                                           logic signed [WORD_W-1:0] val);
    result_t r;
    int p;
    p = pos;
    r.status = ST_DONE;
    r.data = '0;
    case (kind)
      KIND_INSERT: begin
        if (p > stored) begin
          r.status = ST_BADPOS;
        end else if (stored >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = stored; i > p; i--) slots[i] = slots[i-1];
          slots[p] = val;
          stored++;
        end
      end
      KIND_DELETE: begin
        if (p >= stored) begin
          r.status = ST_BADPOS;
        end else begin
          r.data = slots[p];
          for (int i = p + 1; i < stored; i++) slots[i-1] = slots[i];
          stored--;
        end
      end
      KIND_READ: begin
        if (p >= stored) begin
          r.status = ST_BADPOS;
        end else begin
          r.data = slots[p];
        end
      end
      default: begin
      end
    endcase
    r.count = stored[COUNT_W-1:0];
    return r;
  endfunction

  task automatic add_row(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                         logic signed [WORD_W-1:0] val, bit typed,
                         logic [STATUS_W-1:0] status, logic signed [WORD_W-1:0] data,
                         logic [COUNT_W-1:0] count);
    step_row_t row;
    row.kind = kind;
    row.pos = pos;
    row.val = val;
    row.typed = typed;
    row.want.status = status;
    row.want.data = data;
    row.want.count = count;
    script.push_back(row);
  endtask

  task automatic pause_sender();
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_beat(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                           logic signed [WORD_W-1:0] val, bit typed, result_t want);
    result_t predicted;
    pause_sender();
    in_valid <= 1'b1;
    in_kind <= kind;
    in_position <= pos;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
    predicted = list_outcome(kind, pos, val);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation: status %0d data %0d count %0d",
               out_status, out_data, out_count);
        failures++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_status);
          failures++;
        end
        if (out_data !== oldest.data) begin
          $error("data: expected %0d, got %0d", oldest.data, out_data);
          failures++;
        end
        if (out_count !== oldest.count) begin
          $error("count: expected %0d, got %0d", oldest.count, out_count);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[positional_insert_delete_array] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    result_t                  none;
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] val;
    int                       random_sent;
    int                       roll;
    int                       ins_edge;
    int                       del_edge;
    bit                       drained_mid;
    none = '0;
    random_sent = 0;
    drained_mid = 1'b0;

    add_row(KIND_READ,   5'd0,  32'sd0, 1'b1, ST_BADPOS, 32'sd0, 5'd0);
    add_row(KIND_DELETE, 5'd0,  32'sd0, 1'b1, ST_BADPOS, 32'sd0, 5'd0);
    add_row(KIND_INSERT, 5'd1,  32'sd5, 1'b1, ST_BADPOS, 32'sd0, 5'd0);
    add_row(KIND_UNUSED, 5'd31, -32'sd1, 1'b1, ST_DONE, 32'sd0, 5'd0);
    add_row(KIND_INSERT, 5'd0,  32'sh7fffffff, 1'b1, ST_DONE, 32'sd0, 5'd1);
    add_row(KIND_INSERT, 5'd0,  32'sh80000000, 1'b1, ST_DONE, 32'sd0, 5'd2);
    add_row(KIND_INSERT, 5'd2,  32'sd0, 1'b1, ST_DONE, 32'sd0, 5'd3);
    add_row(KIND_READ,   5'd0,  -32'sd1, 1'b1, ST_DONE, 32'sh80000000, 5'd3);
    add_row(KIND_READ,   5'd31, 32'sd0, 1'b1, ST_BADPOS, 32'sd0, 5'd3);
    for (int n = 3; n < CAPACITY; n++) begin
      add_row(KIND_INSERT, POS_W'($urandom_range(n, 0)), $urandom(), 1'b0, ST_DONE, 32'sd0,
              5'd0);
    end
    add_row(KIND_INSERT, 5'd16, 32'sd7, 1'b1, ST_FULL, 32'sd0, 5'd16);
    add_row(KIND_INSERT, 5'd17, 32'sd7, 1'b1, ST_BADPOS, 32'sd0, 5'd16);
    add_row(KIND_DELETE, 5'd15, 32'sd0, 1'b0, ST_DONE, 32'sd0, 5'd0);
    add_row(KIND_DELETE, 5'd0,  32'sd0, 1'b0, ST_DONE, 32'sd0, 5'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      send_beat(script[i].kind, script[i].pos, script[i].val, script[i].typed, script[i].want);
    end
    drain_results();

    while (random_sent < RANDOM_ITEMS) begin
      calm <= (random_sent >= 300 && random_sent < 520);
      case ((random_sent / 120) % 3)
        0: begin
          ins_edge = 65;
          del_edge = 85;
        end
        1: begin
          ins_edge = 25;
          del_edge = 75;
        end
        default: begin
          ins_edge = 40;
          del_edge = 75;
        end
      endcase
      roll = $urandom_range(99);
      if (roll < 2) kind = KIND_UNUSED;
      else if (roll < ins_edge) kind = KIND_INSERT;
      else if (roll < del_edge) kind = KIND_DELETE;
      else kind = KIND_READ;
      if ($urandom_range(99) < 12) pos = POS_W'($urandom_range(31, 0));
      else if (kind == KIND_INSERT) pos = POS_W'($urandom_range(stored, 0));
      else if (stored > 0) pos = POS_W'($urandom_range(stored - 1, 0));
      else pos = POS_W'($urandom_range(3, 0));
      roll = $urandom_range(19);
      if (roll == 0) val = 32'sh7fffffff;
      else if (roll == 1) val = 32'sh80000000;
      else if (roll == 2) val = -32'sd1;
      else if (roll == 3) val = 32'sd0;
      else val = $urandom();
      send_beat(kind, pos, val, 1'b0, none);
      if (kind != KIND_UNUSED) random_sent++;
      if (random_sent == 700 && !drained_mid) begin
        drained_mid = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (failures == 0) begin
      $display("[positional_insert_delete_array] OK");
    end else begin
      $display("[positional_insert_delete_array] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pida_pkg.sv
rtl/core/pida_mem.sv
rtl/core/pida_out.sv
rtl/core/pida_ctrl.sv
rtl/core/positional_insert_delete_array.sv
rtl/core/pida_chk.sv
bench/tb_positional_insert_delete_array.sv
